// ===== hw/rtl/tgq_pkg.sv =====
// Tilt gesture qualifier: shared types, constants and helper functions.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tgq_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_INDEX_W    = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILT_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_COUNT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_LR_US   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_UD_US   = 3'd5;

    localparam logic [14:0] TILT_THRESHOLD_RST = 15'd500;
    localparam logic [7:0]  HOLD_COUNT_RST     = 8'd10;
    localparam logic [31:0] REPEAT_LR_US_RST   = 32'd250000;
    localparam logic [31:0] REPEAT_UD_US_RST   = 32'd1000000;

    localparam logic [1:0] GEST_LEFT  = 2'd0;
    localparam logic [1:0] GEST_RIGHT = 2'd1;
    localparam logic [1:0] GEST_BACK  = 2'd2;
    localparam logic [1:0] GEST_ENTER = 2'd3;

    localparam logic [2:0] LAST_NONE = 3'd0;

    localparam logic [1:0] WAIT_NONE  = 2'd0;
    localparam logic [1:0] WAIT_ENTER = 2'd1;
    localparam logic [1:0] WAIT_BACK  = 2'd2;

    typedef struct packed {
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic [14:0]        tilt_threshold;
        logic [7:0]         hold_count;
        logic [31:0]        repeat_lr_us;
        logic [31:0]        repeat_ud_us;
    } tgq_cfg_t;

    typedef struct packed {
        logic [7:0] flat_count;
        logic [7:0] down_count;
        logic [7:0] up_count;
        logic [7:0] right_count;
        logic [7:0] left_count;
        logic [2:0] last_gesture;
        logic [1:0] release_wait;
    } tgq_state_t;

    // Saturating persistence counter step: zero when the condition drops.
    function automatic logic [7:0] bump(input logic [7:0] c, input logic cond);
        logic [7:0] r;
        if (!cond)
        begin
            r = 8'd0;
        end
        else if (c == 8'hFF)
        begin
            r = c;
        end
        else
        begin
            r = c + 8'd1;
        end
        return r;
    endfunction

    function automatic logic [2:0] last_code(input logic [1:0] g);
        return {1'b0, g} + 3'd1;
    endfunction

endpackage

// ===== hw/rtl/tgq_cfg.sv =====
// Tilt gesture qualifier: configuration register file.
// Depends on tgq_pkg.
`timescale 1ns / 1ps

module tgq_cfg
    import tgq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output tgq_cfg_t               cfg
);

    tgq_cfg_t cfg_reg;
    tgq_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_OFFSET_X:       cfg_next.offset_x       = cfg_data[15:0];
                REG_OFFSET_Y:       cfg_next.offset_y       = cfg_data[15:0];
                REG_TILT_THRESHOLD: cfg_next.tilt_threshold = cfg_data[14:0];
                REG_HOLD_COUNT:     cfg_next.hold_count     = cfg_data[7:0];
                REG_REPEAT_LR_US:   cfg_next.repeat_lr_us   = cfg_data[31:0];
                REG_REPEAT_UD_US:   cfg_next.repeat_ud_us   = cfg_data[31:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x       <= '0;
            cfg_reg.offset_y       <= '0;
            cfg_reg.tilt_threshold <= TILT_THRESHOLD_RST;
            cfg_reg.hold_count     <= HOLD_COUNT_RST;
            cfg_reg.repeat_lr_us   <= REPEAT_LR_US_RST;
            cfg_reg.repeat_ud_us   <= REPEAT_UD_US_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/tgq_step.sv =====
// Tilt gesture qualifier: one-sample next-state and gesture decision logic.
// Depends on tgq_pkg.
`timescale 1ns / 1ps

module tgq_step
    import tgq_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  tgq_cfg_t               cfg,
    input  tgq_state_t             st,
    input  logic [TIME_WIDTH-1:0]  last_time,
    input  logic signed [15:0]     raw_x,
    input  logic signed [15:0]     raw_y,
    input  logic [TIME_WIDTH-1:0]  time_us,
    input  logic                   enter_button,
    input  logic                   back_button,
    output tgq_state_t             st_next,
    output logic [TIME_WIDTH-1:0]  last_time_next,
    output logic                   emit,
    output logic [1:0]             gesture
);

    localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic signed [16:0] thr_pos;
    logic signed [16:0] thr_neg;
    logic [7:0] flat_c, down_c, up_c, right_c, left_c;
    logic [2:0] last_eff;
    logic [TIME_WIDTH-1:0] last_time_eff;
    logic [TIME_WIDTH-1:0] elapsed;
    logic lr_due, ud_due;
    logic ok_right, ok_left, ok_down, ok_up;

    assign ax      = {raw_x[15], raw_x} - {cfg.offset_x[15], cfg.offset_x};
    assign ay      = {raw_y[15], raw_y} - {cfg.offset_y[15], cfg.offset_y};
    assign thr_pos = {2'b00, cfg.tilt_threshold};
    assign thr_neg = -thr_pos;

    assign flat_c  = bump(st.flat_count,
                          (ax < thr_pos) && (ax > thr_neg) && (ay < thr_pos) && (ay > thr_neg));
    assign down_c  = bump(st.down_count,  ax > thr_pos);
    assign up_c    = bump(st.up_count,    ax < thr_neg);
    assign right_c = bump(st.right_count, ay > thr_pos);
    assign left_c  = bump(st.left_count,  ay < thr_neg);

    // A held flat position forgets the previous gesture.
    always_comb
    begin
        if (flat_c > cfg.hold_count)
        begin
            last_eff      = LAST_NONE;
            last_time_eff = '0;
        end
        else
        begin
            last_eff      = st.last_gesture;
            last_time_eff = last_time;
        end
    end

    assign elapsed = time_us - last_time_eff;
    assign lr_due  = CMP_W'(elapsed) > CMP_W'(cfg.repeat_lr_us);
    assign ud_due  = CMP_W'(elapsed) > CMP_W'(cfg.repeat_ud_us);

    assign ok_right = (right_c > cfg.hold_count) && ((last_eff == LAST_NONE) ||
                      ((last_eff == last_code(GEST_RIGHT)) && lr_due));
    assign ok_left  = (left_c > cfg.hold_count) && ((last_eff == LAST_NONE) ||
                      ((last_eff == last_code(GEST_LEFT)) && lr_due));
    assign ok_down  = (down_c > cfg.hold_count) && ((last_eff == LAST_NONE) ||
                      ((last_eff == last_code(GEST_ENTER)) && ud_due));
    assign ok_up    = (up_c > cfg.hold_count) && ((last_eff == LAST_NONE) ||
                      ((last_eff == last_code(GEST_BACK)) && ud_due));

    always_comb
    begin
        st_next        = st;
        last_time_next = last_time;
        emit           = 1'b0;
        gesture        = GEST_LEFT;
        if ((st.release_wait == WAIT_ENTER) || (st.release_wait == WAIT_BACK))
        begin
            if (!((st.release_wait == WAIT_ENTER) ? enter_button : back_button))
            begin
                emit                 = 1'b1;
                gesture              = (st.release_wait == WAIT_ENTER) ? GEST_ENTER : GEST_BACK;
                st_next.release_wait = WAIT_NONE;
                st_next.flat_count   = '0;
                st_next.down_count   = '0;
                st_next.up_count     = '0;
                st_next.right_count  = '0;
                st_next.left_count   = '0;
            end
        end
        else if (enter_button)
        begin
            st_next.release_wait = WAIT_ENTER;
        end
        else if (back_button)
        begin
            st_next.release_wait = WAIT_BACK;
        end
        else
        begin
            st_next.release_wait = WAIT_NONE;
            st_next.flat_count   = flat_c;
            st_next.down_count   = down_c;
            st_next.up_count     = up_c;
            st_next.right_count  = right_c;
            st_next.left_count   = left_c;
            st_next.last_gesture = last_eff;
            last_time_next       = last_time_eff;
            emit = ok_right || ok_left || ok_down || ok_up;
            priority if (ok_right)
            begin
                gesture = GEST_RIGHT;
            end
            else if (ok_left)
            begin
                gesture = GEST_LEFT;
            end
            else if (ok_down)
            begin
                gesture = GEST_ENTER;
            end
            else
            begin
                gesture = GEST_BACK;
            end
            if (emit)
            begin
                st_next.last_gesture = last_code(gesture);
                last_time_next       = time_us;
                st_next.flat_count   = '0;
                st_next.down_count   = '0;
                st_next.up_count     = '0;
                st_next.right_count  = '0;
                st_next.left_count   = '0;
            end
        end
    end

endmodule

// ===== hw/rtl/tilt_gesture_qualifier.sv =====
// Tilt gesture qualifier top level: input register, state, result register.
// Depends on tgq_pkg, tgq_cfg and tgq_step.
// Flow: a sample is registered in the input register on acceptance and decided into
// the result register once that is empty or being read; a gesture it yields is offered on out_valid.
// Throughput: one sample per cycle unless a result stalls; decision logic is combinational.
// Reset (rst_n low, asynchronous): counters, previous gesture and button wait
// clear, configuration registers return to their defaults, both handshakes go empty.
`timescale 1ns / 1ps

module tilt_gesture_qualifier
    import tgq_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [15:0]     raw_x,
    input  logic signed [15:0]     raw_y,
    input  logic [TIME_WIDTH-1:0]  time_us,
    input  logic                   enter_button,
    input  logic                   back_button,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             gesture
);

    tgq_cfg_t cfg;

    logic                  in_valid_reg;
    logic signed [15:0]    x_reg;
    logic signed [15:0]    y_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic                  enter_reg;
    logic                  back_reg;

    tgq_state_t            st_reg;
    tgq_state_t            st_next;
    logic [TIME_WIDTH-1:0] last_time_reg;
    logic [TIME_WIDTH-1:0] last_time_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [1:0]            gesture_reg;

    logic                  step_emit;
    logic [1:0]            step_gesture;
    logic                  advance;
    logic                  accept;

    tgq_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    tgq_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .cfg            (cfg),
        .st             (st_reg),
        .last_time      (last_time_reg),
        .raw_x          (x_reg),
        .raw_y          (y_reg),
        .time_us        (time_reg),
        .enter_button   (enter_reg),
        .back_button    (back_reg),
        .st_next        (st_next),
        .last_time_next (last_time_next),
        .emit           (step_emit),
        .gesture        (step_gesture)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = step_emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            last_time_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= accept || (in_valid_reg && !advance);
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg        <= st_next;
                last_time_reg <= last_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= raw_x;
            y_reg     <= raw_y;
            time_reg  <= time_us;
            enter_reg <= enter_button;
            back_reg  <= back_button;
        end
        if (advance && step_emit)
        begin
            gesture_reg <= step_gesture;
        end
    end

    assign out_valid = out_valid_reg;
    assign gesture   = gesture_reg;

endmodule

// ===== hw/rtl/tgq_checker.sv =====
// Tilt gesture qualifier: port-level checker and its bind to the top level.
// Depends on tgq_pkg and tilt_gesture_qualifier.
`timescale 1ns / 1ps

module tgq_checker
    import tgq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] gesture
);

    // Hold a stalled gesture word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gesture))
        else $error("gesture word changed or dropped while stalled");

    // Keep input open whenever the result side can drain.
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with a free result slot");

    // A fresh result follows an accepted sample, checked with $past on the input handshake.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result word appeared without a matching sample");

endmodule

bind tilt_gesture_qualifier tgq_checker u_tgq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gesture   (gesture)
);
